// ===== hdl/sqlls_pkg.sv =====
// ----------------------------------------------------------------------------
// SQL literal scanner package
// Shared result type, lookahead codes, character constants and queue sizing.
// ----------------------------------------------------------------------------
package sqlls_pkg;

   // Which byte is waiting for its successor.
   typedef enum logic [2:0] {
      PEND_NONE  = 3'd0,
      PEND_LEAD  = 3'd1,
      PEND_SLASH = 3'd2,
      PEND_STAR  = 3'd3,
      PEND_DASH  = 3'd4,
      PEND_QUOTE = 3'd5
   } pend_type;

   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   // Result queue: four entries, up to two written per request.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_LW    = 3;

   typedef struct packed {
      logic               last;
      logic               found;
      logic signed [16:0] word_start;
      logic [15:0]        length;
   } rsp_item_type;

   typedef struct packed {
      logic [FIFO_LW-1:0] level;
      logic               room;
   } fifo_status_type;

endpackage

// ===== hdl/sqlls_scan.sv =====
// ----------------------------------------------------------------------------
// SQL literal scanner state and byte step
// Holds the segment state and computes, for one byte, the next state and
// up to two finished segment results.
// ----------------------------------------------------------------------------
module sqlls_scan
   import sqlls_pkg::*;
#(
   parameter int POSITION_WIDTH = 16,
   parameter int DEPTH_WIDTH    = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   data_byte,
   input  logic         end_of_input,
   output logic [1:0]   res_cnt,
   output rsp_item_type res_a,
   output rsp_item_type res_b
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
   localparam logic [DEPTH_WIDTH-1:0]    DEP_MAX = {DEPTH_WIDTH{1'b1}};

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [DEPTH_WIDTH-1:0]    depth_ff, depth_in;
   logic                      line_ff, line_in;
   logic                      lit_ff, lit_in;
   pend_type                  pend_ff, pend_in;
   logic                      none_ff, none_in;
   logic [POSITION_WIDTH-1:0] start_ff, start_in;

   logic                      matched;
   logic                      close;
   logic [POSITION_WIDTH-1:0] b_pos;
   logic [DEPTH_WIDTH-1:0]    b_depth;
   logic                      b_line, b_lit, b_none;
   logic [POSITION_WIDTH-1:0] b_start;
   rsp_item_type              close_item, eoi_item;

   function automatic logic [POSITION_WIDTH-1:0] adv(input logic [POSITION_WIDTH-1:0] p);
      return (p == POS_MAX) ? p : p + POSITION_WIDTH'(1);
   endfunction

   function automatic rsp_item_type make_item(
      input logic [POSITION_WIDTH-1:0] pos,
      input logic                      none,
      input logic [POSITION_WIDTH-1:0] start,
      input logic                      lit,
      input logic                      last
   );
      rsp_item_type it;
      logic [32:0]  wpos;
      logic [32:0]  wst;
      wpos = 33'(pos);
      wst  = 33'(start);
      it.length = (wpos > 33'(LEN_MAX)) ? LEN_MAX : wpos[15:0];
      if (none) begin
         it.word_start = -17'sd1;
      end else if (wst > 33'(LEN_MAX)) begin
         it.word_start = {1'b0, LEN_MAX};
      end else begin
         it.word_start = {1'b0, wst[15:0]};
      end
      it.found = lit;
      it.last  = last;
      return it;
   endfunction

   always_comb begin
      pos_in   = pos_ff;
      depth_in = depth_ff;
      line_in  = line_ff;
      lit_in   = lit_ff;
      pend_in  = PEND_NONE;
      none_in  = none_ff;
      start_in = start_ff;
      close    = 1'b0;
      b_pos    = pos_ff;
      b_depth  = depth_ff;
      b_line   = line_ff;
      b_lit    = lit_ff;
      b_none   = none_ff;
      b_start  = start_ff;

      matched = (pend_ff == PEND_LEAD)
             || (pend_ff == PEND_SLASH && data_byte == CH_STAR)
             || (pend_ff == PEND_STAR  && data_byte == CH_SLASH)
             || (pend_ff == PEND_DASH  && data_byte == CH_DASH)
             || (pend_ff == PEND_QUOTE && data_byte == CH_QUOTE);

      if (matched) begin
         pos_in = adv(pos_ff);
         if (pend_ff == PEND_SLASH && depth_ff != DEP_MAX) begin
            depth_in = depth_ff + DEPTH_WIDTH'(1);
         end
         if (pend_ff == PEND_STAR && depth_ff != '0) begin
            depth_in = depth_ff - DEPTH_WIDTH'(1);
         end
         if (pend_ff == PEND_DASH) begin
            line_in = 1'b1;
         end
      end else begin
         // A quote followed by anything but a quote closes the segment first.
         if (pend_ff == PEND_QUOTE) begin
            close   = 1'b1;
            b_pos   = '0;
            b_depth = '0;
            b_line  = 1'b0;
            b_lit   = 1'b0;
            b_none  = 1'b1;
            b_start = '0;
         end
         pos_in   = adv(b_pos);
         depth_in = b_depth;
         line_in  = b_line;
         lit_in   = b_lit;
         none_in  = b_none;
         start_in = b_start;
         if (data_byte[7]) begin
            pend_in = PEND_LEAD;
         end else begin
            case (data_byte)
               CH_QUOTE: begin
                  if (b_lit) begin
                     pend_in = PEND_QUOTE;
                  end else if (b_depth == '0 && !b_line) begin
                     lit_in   = 1'b1;
                     none_in  = 1'b0;
                     start_in = b_pos;
                  end
               end
               CH_SLASH: begin
                  if (!b_lit) pend_in = PEND_SLASH;
               end
               CH_STAR: begin
                  if (!b_lit) pend_in = PEND_STAR;
               end
               CH_DASH: begin
                  if (!b_lit) pend_in = PEND_DASH;
               end
               CH_LF, CH_CR: begin
                  line_in = 1'b0;
               end
               default: begin
                  if (!b_lit) begin
                     none_in  = 1'b0;
                     start_in = adv(b_pos);
                  end
               end
            endcase
         end
      end

      close_item = make_item(pos_ff, none_ff, start_ff, lit_ff, !end_of_input);
      eoi_item   = make_item(pos_in, none_in, start_in, lit_in, 1'b1);
      res_a      = close ? close_item : eoi_item;
      res_b      = eoi_item;
      res_cnt    = 2'(close) + 2'(end_of_input);

      if (end_of_input) begin
         pos_in   = '0;
         depth_in = '0;
         line_in  = 1'b0;
         lit_in   = 1'b0;
         pend_in  = PEND_NONE;
         none_in  = 1'b1;
         start_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         depth_ff <= '0;
         line_ff  <= 1'b0;
         lit_ff   <= 1'b0;
         pend_ff  <= PEND_NONE;
         none_ff  <= 1'b1;
         start_ff <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         depth_ff <= depth_in;
         line_ff  <= line_in;
         lit_ff   <= lit_in;
         pend_ff  <= pend_in;
         none_ff  <= none_in;
         start_ff <= start_in;
      end
   end

endmodule

// ===== hdl/sqlls_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// SQL literal scanner result queue
// Four-entry queue that takes zero, one or two results per cycle and
// hands them out one at a time.
// ----------------------------------------------------------------------------
module sqlls_rsp_fifo
   import sqlls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [1:0]      push_cnt,
   input  rsp_item_type    push_a,
   input  rsp_item_type    push_b,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_item_type    out_item,
   output fifo_status_type status
);

   rsp_item_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, wr_in;
   logic [FIFO_AW-1:0] rd_ff, rd_in;
   logic [FIFO_LW-1:0] level_ff, level_in;
   logic               pop;
   logic [FIFO_AW-1:0] wr_next;

   assign out_valid     = (level_ff != '0);
   assign out_item      = mem_ff[rd_ff];
   assign pop           = out_valid && out_ready;
   assign wr_next       = wr_ff + FIFO_AW'(1);
   assign status.level  = level_ff;
   // Room for the largest burst a single request can produce.
   assign status.room   = (level_ff <= FIFO_LW'(FIFO_DEPTH - 2));

   always_comb begin
      wr_in    = wr_ff + FIFO_AW'(push_cnt);
      rd_in    = pop ? rd_ff + FIFO_AW'(1) : rd_ff;
      level_in = level_ff + FIFO_LW'(push_cnt) - FIFO_LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) mem_ff[wr_ff] <= push_a;
      if (push_cnt == 2'd2) mem_ff[wr_next] <= push_b;
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

// ===== hdl/sql_literal_scanner.sv =====
// ----------------------------------------------------------------------------
// SQL literal scanner
// Cuts a byte stream of SQL text into segments that end after a quoted
// literal or at the end of the text, and reports length, start and flag.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                  tlast
//  req      in   [7:0] data_byte                        end_of_input
//  rsp      out  [15:0] segment_length,                 last_of_run
//                [32:16] word_start, [33] found_literal
//
// One byte is accepted per cycle while req_tready is high; it is registered,
// then the scan step and the result queue write happen once the queue has room.
// A byte that yields two results puts both in the queue, handed out in turn.
// Reset is synchronous and returns the scanner to an empty segment.
// rsp_tready low fills the four-entry result queue; req_tready drops while a
// byte is held and fewer than two entries are free.
// ----------------------------------------------------------------------------
module sql_literal_scanner
   import sqlls_pkg::*;
#(
   parameter int POSITION_WIDTH = 16,
   parameter int DEPTH_WIDTH    = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] segment_length, [32:16] word_start,
                                    // [33] found_literal, [39:34] zero
   output logic        rsp_tlast    // last_of_run
);

   logic            s1_vld_ff, s1_vld_in;
   logic [7:0]      s1_byte_ff;
   logic            s1_eoi_ff;
   logic            fire;
   logic [1:0]      res_cnt;
   logic [1:0]      push_cnt;
   rsp_item_type    res_a, res_b, out_item;
   fifo_status_type fstat;

   assign fire       = s1_vld_ff && fstat.room;
   assign req_tready = !s1_vld_ff || fstat.room;
   assign push_cnt   = fire ? res_cnt : 2'd0;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_tready) s1_vld_in = req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_eoi_ff  <= req_tlast;
      end
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   sqlls_scan #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .DEPTH_WIDTH    (DEPTH_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (fire),
      .data_byte    (s1_byte_ff),
      .end_of_input (s1_eoi_ff),
      .res_cnt      (res_cnt),
      .res_a        (res_a),
      .res_b        (res_b)
   );

   sqlls_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_a    (res_a),
      .push_b    (res_b),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item),
      .status    (fstat)
   );

   assign rsp_tdata = {6'd0, out_item.found, out_item.word_start, out_item.length};
   assign rsp_tlast = out_item.last;

`ifndef SYNTHESIS
   // The queue never holds more than its depth.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fstat.level <= FIFO_LW'(FIFO_DEPTH))
      else $error("result queue overfilled");

   // The final byte of a text always closes a segment.
   a_eoi_result: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_eoi_ff) |-> (res_cnt != 2'd0))
      else $error("end of input produced no result");

   // Two results from one byte only when the byte also ends the text.
   a_pair_needs_eoi: assert property (@(posedge clock) disable iff (reset)
      (fire && res_cnt == 2'd2) |-> s1_eoi_ff)
      else $error("two results without end of input");

   // A request is only passed to the scanner with queue room for both results.
   a_room_on_fire: assert property (@(posedge clock) disable iff (reset)
      fire |-> (fstat.level <= FIFO_LW'(FIFO_DEPTH - 2)))
      else $error("scan step without queue room");
`endif

endmodule
